[rtl/dss_pkg.sv]
// Shared types and constants for the descending selection sorter.
`timescale 1ns / 1ps

package dss_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               is_last;
    } in_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               run_end;
        logic               overflowed;
    } out_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

[rtl/dss_cell.sv]
// One cell of the sorting row: holds a value, inserts in order or shifts toward the head.
`timescale 1ns / 1ps

module dss_cell
    import dss_pkg::*;
(
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic               valid,
    input  logic signed [31:0] new_val,
    input  logic               up_keep,
    input  logic signed [31:0] up_val,
    input  logic signed [31:0] down_val,
    output logic               keep,
    output logic signed [31:0] val
);

    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;

    assign keep = valid && (val_reg >= new_val);
    assign val  = val_reg;

    always_comb begin
        val_next = val_reg;
        if (ctrl.insert) begin
            if (keep) begin
                val_next = val_reg;
            end else if (up_keep) begin
                val_next = new_val;
            end else begin
                val_next = up_val;
            end
        end else if (ctrl.shift) begin
            val_next = down_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

[rtl/descending_selection_sorter_core.sv]
// Top level of the descending sorter: a row of insertion cells and the drain control.
`timescale 1ns / 1ps

// Values enter one per cycle and are placed in order as they arrive, in a row
// of CAPACITY cells that compare against the incoming value in parallel and
// pass data to their neighbors. The transaction marked is_last closes the set;
// the row then shifts toward the head and gives one result per cycle, largest
// first, while the output side takes them. No input is taken while a set
// drains. Values beyond CAPACITY are dropped and flag the whole run.

module descending_selection_sorter_core
    import dss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    cell_ctrl_t         ctrl;
    logic               in_fire;
    logic               out_free;
    logic               full;
    logic signed [31:0] cell_val  [CAPACITY];
    logic               cell_keep [CAPACITY];

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        ctrl.insert = in_fire && !full;
        ctrl.shift  = (state_reg == ST_DRAIN) && out_free;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic               up_keep;
        logic signed [31:0] up_val;
        logic signed [31:0] down_val;

        if (i == 0) begin : g_head
            assign up_keep = 1'b1;
            assign up_val  = s_data.sample_value;
        end else begin : g_body
            assign up_keep = cell_keep[i-1];
            assign up_val  = cell_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign down_val = cell_val[i];
        end else begin : g_inner
            assign down_val = cell_val[i+1];
        end

        dss_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .valid    (CNT_W'(i) < count_reg),
            .new_val  (s_data.sample_value),
            .up_keep  (up_keep),
            .up_val   (up_val),
            .down_val (down_val),
            .keep     (cell_keep[i]),
            .val      (cell_val[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_data.is_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.sorted_value = cell_val[0];
                    m_data_next.run_end      = (count_reg == CNT_W'(1));
                    m_data_next.overflowed   = ovf_reg;
                    count_next               = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
